>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property must hold at every rising clock edge outside reset
`define ASSERT_AT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("assertion failed");

// condition must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
		else $error("forbidden condition seen");

`else

`define ASSERT_AT(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

>>> rtl/core/i2cwfs_pkg.sv
// ----------------------------------------------------------------------------
// i2cwfs_pkg
// Shared types and constants of the i2c write frame serializer.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cwfs_pkg;

	// bus symbol codes
	localparam logic [1:0] SYM_START = 2'd0;
	localparam logic [1:0] SYM_BIT   = 2'd1;
	localparam logic [1:0] SYM_STOP  = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_SLAVE_ADDRESS   = 2'd0;
	localparam logic [1:0] REG_COMMAND_CONTROL = 2'd1;
	localparam logic [1:0] REG_DATA_CONTROL    = 2'd2;

	localparam logic [7:0] RST_SLAVE_ADDRESS   = 8'd120;
	localparam logic [7:0] RST_COMMAND_CONTROL = 8'd0;
	localparam logic [7:0] RST_DATA_CONTROL    = 8'd64;

	localparam logic       MODE_DATA = 1'b1;

	// sequencer slots: start is slot 0, stop is slot 28
	localparam logic [4:0] STOP_SLOT = 5'd28;
	localparam logic [3:0] ACK_SLOT  = 4'd8;

	typedef struct packed {
		logic       mode;
		logic [7:0] payload;
	} in_word_t;

	typedef struct packed {
		logic [1:0] symbol;
		logic       sda_level;
		logic       last;
	} out_word_t;

	// three frame bytes, first byte on the left
	typedef struct packed {
		logic [7:0] addr_byte;
		logic [7:0] ctrl_byte;
		logic [7:0] data_byte;
	} frame_t;

	typedef struct packed {
		logic       busy;
		logic [4:0] slot;
	} back_status_t;

endpackage

`default_nettype wire

>>> rtl/core/i2c_write_frame_serializer_core.sv
// ----------------------------------------------------------------------------
// i2c_write_frame_serializer_core
// Turns each pushed word into one I2C write frame of 29 bus symbols.
// ----------------------------------------------------------------------------
// Each pushed word (mode, payload) becomes start, slave address, control byte
// picked by mode, payload, stop; every byte is eight bit pulses MSB first and
// a released-SDA ack slot, so one word gives 29 result words. The sequencer
// emits one symbol per cycle while its output is popped or empty. Words are
// taken while the frame queue has room: up to QUEUE_DEPTH frames wait behind
// the one being sent, and a result waiting at the output does not block
// acceptance. The control byte is chosen when the word is pushed; the user
// must write registers only while the block is idle; it does not enforce this.
`default_nettype none

`include "assert_macros.svh"

module i2c_write_frame_serializer_core
	import i2cwfs_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	output logic            full,
	input  wire in_word_t   in_word,
	output logic            empty,
	input  wire logic       pop,
	output out_word_t       out_word,
	input  wire logic       cfg_wen,
	input  wire logic [1:0] cfg_idx,
	input  wire logic [7:0] cfg_wdata
);

	frame_t       frame;
	frame_t       q_data;
	logic         q_empty;
	logic         q_pop;
	back_status_t status;

	i2cwfs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.in_word   (in_word),
		.frame     (frame)
	);

	i2cwfs_fifo #(
		.WIDTH ($bits(frame_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (frame),
		.full   (full),
		.pop    (q_pop),
		.dout   (q_data),
		.empty  (q_empty)
	);

	i2cwfs_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_data   (q_data),
		.q_empty  (q_empty),
		.q_pop    (q_pop),
		.out_word (out_word),
		.empty    (empty),
		.pop      (pop),
		.status   (status)
	);

	`ASSERT_AT(a_last_is_stop, clk, arst_n,
		!empty |-> (out_word.last == (out_word.symbol == SYM_STOP)))
	`ASSERT_AT(a_start_loads_seq, clk, arst_n,
		(!empty && out_word.symbol == SYM_START) |-> (status.busy && status.slot == 5'd1))
	`ASSERT_NEVER(a_no_bad_symbol, clk, arst_n,
		!empty && out_word.symbol != SYM_START && out_word.symbol != SYM_BIT
		&& out_word.symbol != SYM_STOP)
	`ASSERT_AT(a_pop_only_when_idle, clk, arst_n,
		q_pop |=> (status.busy && status.slot == 5'd1))

endmodule

`default_nettype wire

>>> rtl/core/i2cwfs_front.sv
// ----------------------------------------------------------------------------
// i2cwfs_front
// Configuration registers and frame builder: turns an input word into the
// three bytes of its frame.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cwfs_front
	import i2cwfs_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_wen,
	input  wire logic [1:0] cfg_idx,
	input  wire logic [7:0] cfg_wdata,
	input  wire in_word_t   in_word,
	output frame_t          frame
);

	logic [7:0] slave_address_q;
	logic [7:0] command_control_q;
	logic [7:0] data_control_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_address_q   <= RST_SLAVE_ADDRESS;
			command_control_q <= RST_COMMAND_CONTROL;
			data_control_q    <= RST_DATA_CONTROL;
		end else if (cfg_wen) begin
			unique case (cfg_idx)
				REG_SLAVE_ADDRESS:   slave_address_q   <= cfg_wdata;
				REG_COMMAND_CONTROL: command_control_q <= cfg_wdata;
				REG_DATA_CONTROL:    data_control_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		frame.addr_byte = slave_address_q;
		frame.ctrl_byte = (in_word.mode == MODE_DATA) ? data_control_q : command_control_q;
		frame.data_byte = in_word.payload;
	end

endmodule

`default_nettype wire

>>> rtl/core/i2cwfs_fifo.sv
// ----------------------------------------------------------------------------
// i2cwfs_fifo
// Small register queue of built frames between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cwfs_fifo #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] din,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      dout,
	output logic                  empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CNT_FULL);
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/i2cwfs_back.sv
// ----------------------------------------------------------------------------
// i2cwfs_back
// Symbol sequencer: walks one frame as start, 27 bit pulses and stop, one
// symbol per cycle while the output is popped or empty, into an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cwfs_back
	import i2cwfs_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire frame_t q_data,
	input  wire logic   q_empty,
	output logic        q_pop,
	output out_word_t   out_word,
	output logic        empty,
	input  wire logic   pop,
	output back_status_t status
);

	localparam int FRAME_BITS = $bits(frame_t);

	logic                  busy_q,      busy_d;
	logic [4:0]            slot_q,      slot_d;
	logic [3:0]            bit_cnt_q,   bit_cnt_d;
	logic [FRAME_BITS-1:0] shift_q,     shift_d;
	logic                  out_valid_q, out_valid_d;
	out_word_t             out_q,       out_d;
	logic                  advance;

	assign advance = !out_valid_q || pop;

	always_comb begin
		busy_d      = busy_q;
		slot_d      = slot_q;
		bit_cnt_d   = bit_cnt_q;
		shift_d     = shift_q;
		out_valid_d = out_valid_q;
		out_d       = out_q;
		q_pop       = 1'b0;
		if (advance) begin
			out_valid_d = 1'b0;
			if (busy_q) begin
				out_valid_d = 1'b1;
				if (slot_q == STOP_SLOT) begin
					out_d  = '{symbol: SYM_STOP, sda_level: 1'b0, last: 1'b1};
					busy_d = 1'b0;
				end else if (bit_cnt_q == ACK_SLOT) begin
					// ack slot, sda released
					out_d     = '{symbol: SYM_BIT, sda_level: 1'b1, last: 1'b0};
					bit_cnt_d = '0;
					slot_d    = slot_q + 1'b1;
				end else begin
					out_d     = '{symbol: SYM_BIT, sda_level: shift_q[FRAME_BITS-1],
						last: 1'b0};
					shift_d   = {shift_q[FRAME_BITS-2:0], 1'b0};
					bit_cnt_d = bit_cnt_q + 1'b1;
					slot_d    = slot_q + 1'b1;
				end
			end else if (!q_empty) begin
				q_pop       = 1'b1;
				out_valid_d = 1'b1;
				out_d       = '{symbol: SYM_START, sda_level: 1'b0, last: 1'b0};
				shift_d     = q_data;
				busy_d      = 1'b1;
				slot_d      = 5'd1;
				bit_cnt_d   = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			slot_q      <= '0;
			bit_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			busy_q      <= busy_d;
			slot_q      <= slot_d;
			bit_cnt_q   <= bit_cnt_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		shift_q <= shift_d;
		out_q   <= out_d;
	end

	assign out_word      = out_q;
	assign empty         = !out_valid_q;
	assign status.busy   = busy_q;
	assign status.slot   = slot_q;

endmodule

`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the i2c write frame serializer core.
// ----------------------------------------------------------------------------
// Pushes directed and random words through the queue-style ports and expands
// each accepted word into its 29 expected bus symbols in a scoreboard. Every
// popped symbol is checked field by field against the oldest expected one.
// Registers change only while the block is idle, from reset values through
// all-zero, all-one and random settings. Both sides idle at random, with one
// phase of no idling and one long output hold-off that backs up the input.
// ----------------------------------------------------------------------------

module tb;
	import i2cwfs_pkg::*;

	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam int PHASES = 5;
	localparam int PHASE_WORDS = 72;
	localparam int PRESSURE_WORDS = 10;
	localparam int HOLD_CYCLES = 400;
	localparam int GAP_PERCENT = 38;
	localparam int SETTLE_CYCLES = 40;

	class frame_scoreboard;
		logic [7:0] slave_address;
		logic [7:0] command_control;
		logic [7:0] data_control;
		out_word_t  symbol_queue[$];
		int unsigned errors;

		function new();
			slave_address   = RST_SLAVE_ADDRESS;
			command_control = RST_COMMAND_CONTROL;
			data_control    = RST_DATA_CONTROL;
			errors          = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [7:0] val);
			case (idx)
				REG_SLAVE_ADDRESS: slave_address = val;
				REG_COMMAND_CONTROL: command_control = val;
				REG_DATA_CONTROL: data_control = val;
				default: ;
			endcase
		endfunction

		function void add_symbol(logic [1:0] sym, logic sda, logic fin);
			out_word_t s;
			s.symbol    = sym;
			s.sda_level = sda;
			s.last      = fin;
			symbol_queue.push_back(s);
		endfunction

		function void add_byte(logic [7:0] b);
			for (int i = 7; i >= 0; i--)
				add_symbol(SYM_BIT, b[i], 1'b0);
			// ack slot, sda released
			add_symbol(SYM_BIT, 1'b1, 1'b0);
		endfunction

		function void note_word(in_word_t w);
			add_symbol(SYM_START, 1'b0, 1'b0);
			add_byte(slave_address);
			add_byte((w.mode == MODE_DATA) ? data_control : command_control);
			add_byte(w.payload);
			add_symbol(SYM_STOP, 1'b0, 1'b1);
		endfunction

		function void check_symbol(out_word_t got);
			out_word_t want;
			if (symbol_queue.size() == 0) begin
				$display("%0t: unexpected word, expected none, got %h", $time, got);
				errors++;
				return;
			end
			want = symbol_queue.pop_front();
			if (got.symbol !== want.symbol) begin
				$display("%0t: symbol mismatch, expected %0d, got %0d",
					$time, want.symbol, got.symbol);
				errors++;
			end
			if (got.sda_level !== want.sda_level) begin
				$display("%0t: sda_level mismatch, expected %0d, got %0d",
					$time, want.sda_level, got.sda_level);
				errors++;
			end
			if (got.last !== want.last) begin
				$display("%0t: last mismatch, expected %0d, got %0d",
					$time, want.last, got.last);
				errors++;
			end
		endfunction

		function int pending();
			return symbol_queue.size();
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic       full;
	in_word_t   in_word = '0;
	logic       empty;
	logic       pop = 1'b0;
	out_word_t  out_word;
	logic       cfg_wen = 1'b0;
	logic [1:0] cfg_idx = REG_SLAVE_ADDRESS;
	logic [7:0] cfg_wdata = '0;

	logic tx_gaps = 1'b1;
	logic rx_gaps = 1'b1;
	logic hold_start = 1'b0;
	int   hold_left = 0;

	frame_scoreboard sb;

	i2c_write_frame_serializer_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.in_word(in_word),
		.empty(empty),
		.pop(pop),
		.out_word(out_word),
		.cfg_wen(cfg_wen),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#1000000;
		$display("tb: FAIL");
		$finish;
	end

	// receiver side: random pop with an optional long hold-off
	always @(negedge clk) begin
		if (hold_start) begin
			hold_left  = HOLD_CYCLES;
			hold_start = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			pop = 1'b0;
		end else if (!arst_n) begin
			pop = 1'b0;
		end else begin
			pop = rx_gaps ? ($urandom_range(99) >= GAP_PERCENT) : 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			sb.check_symbol(out_word);
	end

	// called at a falling edge, returns at a falling edge
	task automatic push_word(in_word_t w);
		if (tx_gaps && $urandom_range(99) < GAP_PERCENT) begin
			push = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		push    = 1'b1;
		in_word = w;
		do @(posedge clk); while (full);
		sb.note_word(w);
		@(negedge clk);
	endtask

	task automatic push_random_word();
		in_word_t w;
		w.mode    = 1'($urandom_range(1));
		w.payload = 8'($urandom_range(255));
		push_word(w);
	endtask

	task automatic drain();
		push = 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	task automatic set_reg(logic [1:0] idx, logic [7:0] val);
		cfg_wen   = 1'b1;
		cfg_idx   = idx;
		cfg_wdata = val;
		@(posedge clk);
		sb.write_reg(idx, val);
		@(negedge clk);
	endtask

	task automatic load_regs(logic [7:0] addr, logic [7:0] cmd, logic [7:0] dat);
		set_reg(REG_SLAVE_ADDRESS, addr);
		set_reg(REG_COMMAND_CONTROL, cmd);
		set_reg(REG_DATA_CONTROL, dat);
		cfg_wen = 1'b0;
	endtask

	task automatic push_pair(logic [7:0] cmd_payload, logic [7:0] dat_payload);
		in_word_t w;
		w.mode    = ~MODE_DATA;
		w.payload = cmd_payload;
		push_word(w);
		w.mode    = MODE_DATA;
		w.payload = dat_payload;
		push_word(w);
	endtask

	initial begin
		logic [7:0] corner_bytes[6];
		corner_bytes = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'hAA, 8'h55};
		sb = new();
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset register values
		foreach (corner_bytes[i])
			push_pair(corner_bytes[i], corner_bytes[i]);
		drain();

		// all-zero registers, a write to the unused index must be dropped
		set_reg(REG_UNUSED, 8'hA5);
		load_regs(8'h00, 8'h00, 8'h00);
		set_reg(REG_UNUSED, 8'hFF);
		cfg_wen = 1'b0;
		push_pair(8'h00, 8'hFF);
		push_pair(8'h5A, 8'hA5);
		drain();

		// all-one registers
		load_regs(8'hFF, 8'hFF, 8'hFF);
		push_pair(8'h00, 8'hFF);
		push_pair(8'h5A, 8'hA5);
		drain();

		for (int p = 0; p < PHASES; p++) begin
			tx_gaps = (p != 1);
			rx_gaps = (p != 1);
			load_regs(8'($urandom_range(255)), 8'($urandom_range(255)),
				8'($urandom_range(255)));
			if (p == 3) begin
				// output held off while input keeps coming
				hold_start = 1'b1;
				tx_gaps    = 1'b0;
				repeat (PRESSURE_WORDS) push_random_word();
				tx_gaps    = 1'b1;
			end
			repeat (PHASE_WORDS) push_random_word();
			drain();
		end

		repeat (SETTLE_CYCLES) @(negedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/i2cwfs_pkg.sv
rtl/core/i2cwfs_front.sv
rtl/core/i2cwfs_fifo.sv
rtl/core/i2cwfs_back.sv
rtl/core/i2c_write_frame_serializer_core.sv
bench/tb.sv
